[hw/rtl/lcnr_pkg.sv]
package lcnr_pkg;

	localparam int VALUE_BITS = 32;
	localparam longint unsigned MAX_ITEMS = 65535;
	localparam int COUNT_BITS = 16;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	// Position stops at the smaller of the item limit less one and the counter maximum.
	localparam logic [COUNT_BITS-1:0] POSITION_CAP =
		((MAX_ITEMS - 1) > 64'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(MAX_ITEMS - 1);

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} lcnr_cmd_t;

	typedef struct packed {
		logic first;
		logic gcd_done;
		logic last;
		logic out_full;
	} lcnr_sts_t;

endpackage

[hw/rtl/lcnr_in_if.sv]
interface lcnr_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;
	logic        last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

[hw/rtl/lcnr_out_if.sv]
interface lcnr_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] run_start;
	logic [15:0] run_length;

	modport source (output valid, output run_start, output run_length, input ready);
	modport sink (input valid, input run_start, input run_length, output ready);
endinterface

[hw/rtl/lcnr_ctrl.sv]
module lcnr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lcnr_pkg::lcnr_sts_t sts,
	output lcnr_pkg::lcnr_cmd_t cmd
);
	import lcnr_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_GCD    = 2'd1;
	localparam logic [1:0] S_UPDATE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd        = '0;
		cmd.load   = accept;
		cmd.step   = (state_q == S_GCD) && !sts.gcd_done;
		// A final item waits here until the previous result has been taken.
		cmd.commit = (state_q == S_UPDATE) && !(sts.last && sts.out_full);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = sts.first ? S_UPDATE : S_GCD;
				end
			end
			S_GCD: begin
				if (sts.gcd_done) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				if (cmd.commit) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hw/rtl/lcnr_dp.sv]
module lcnr_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         value,
	input  logic                last,
	input  lcnr_pkg::lcnr_cmd_t cmd,
	output lcnr_pkg::lcnr_sts_t sts,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [15:0]         run_start,
	output logic [15:0]         run_length
);
	import lcnr_pkg::*;

	value_t prev_q;
	value_t value_q;
	logic   last_q;
	value_t a_q;
	value_t b_q;
	count_t position_q;
	count_t current_run_q;
	count_t best_run_q;
	count_t best_start_q;
	logic   out_valid_q;
	count_t out_start_q;
	count_t out_length_q;

	logic   a_zero;
	logic   b_zero;
	logic   gcd_done;
	logic   coprime;

	count_t           run_next;
	logic [COUNT_BITS:0] idx_plus;
	logic             better;
	count_t           start_next;
	count_t           best_run_d;
	count_t           best_start_d;
	count_t           current_run_d;

	// Binary gcd: only whether the gcd is one matters. A zero operand gives the other
	// operand as gcd, and two even operands can never be coprime.
	assign a_zero   = (a_q == '0);
	assign b_zero   = (b_q == '0);
	assign gcd_done = a_zero || b_zero || (a_q == b_q) || (!a_q[0] && !b_q[0]);
	assign coprime  = a_zero ? (b_q == value_t'(1)) :
		b_zero ? (a_q == value_t'(1)) :
		((a_q == b_q) && (a_q == value_t'(1)));

	always_comb begin
		run_next      = (current_run_q < COUNT_MAX) ? current_run_q + count_t'(1) : current_run_q;
		idx_plus      = {1'b0, position_q} + (COUNT_BITS+1)'(1);
		better        = run_next > best_run_q;
		start_next    = ({1'b0, run_next} > idx_plus) ? '0 :
			COUNT_BITS'(idx_plus - {1'b0, run_next});
		best_run_d    = best_run_q;
		best_start_d  = best_start_q;
		current_run_d = current_run_q;
		if (position_q != '0) begin
			if (coprime) begin
				current_run_d = run_next;
				if (better) begin
					best_run_d   = run_next;
					best_start_d = start_next;
				end
			end else begin
				current_run_d = count_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value[VALUE_BITS-1:0];
			last_q  <= last;
			a_q     <= prev_q;
			b_q     <= value[VALUE_BITS-1:0];
		end else if (cmd.step) begin
			if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q > b_q) begin
				a_q <= a_q - b_q;
			end else begin
				b_q <= b_q - a_q;
			end
		end
		if (cmd.commit && last_q) begin
			out_start_q  <= best_start_d;
			out_length_q <= best_run_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q        <= '0;
			position_q    <= '0;
			current_run_q <= count_t'(1);
			best_run_q    <= '0;
			best_start_q  <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.commit) begin
				if (last_q) begin
					prev_q        <= '0;
					position_q    <= '0;
					current_run_q <= count_t'(1);
					best_run_q    <= '0;
					best_start_q  <= '0;
				end else begin
					prev_q        <= value_q;
					current_run_q <= current_run_d;
					best_run_q    <= best_run_d;
					best_start_q  <= best_start_d;
					if (position_q < POSITION_CAP) begin
						position_q <= position_q + count_t'(1);
					end
				end
			end
			if (cmd.commit && last_q) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts          = '0;
		sts.first    = (position_q == '0);
		sts.gcd_done = gcd_done;
		sts.last     = last_q;
		sts.out_full = out_valid_q;
	end

	assign out_valid  = out_valid_q;
	assign run_start  = out_start_q;
	assign run_length = out_length_q;

endmodule

[hw/rtl/longest_coprime_neighbour_run.sv]
// An item is accepted in the idle state and then occupies the block through its binary gcd
// steps (one shift or one subtract per cycle) and its update; the first item of a sequence has
// no pair and skips the gcd steps. The result appears in the output register in the cycle
// after the final item's update; the next sequence may start while it waits. A final item
// stalls only if the previous result is still untaken. Reset is asynchronous, active low,
// and returns all run state.
module longest_coprime_neighbour_run (
	input  logic       clk,
	input  logic       arst_n,
	lcnr_in_if.sink    in,
	lcnr_out_if.source out
);
	import lcnr_pkg::*;

	lcnr_cmd_t cmd;
	lcnr_sts_t sts;

	lcnr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in.valid),
		.in_ready (in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lcnr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (in.value),
		.last        (in.last),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out.valid),
		.out_ready   (out.ready),
		.run_start   (out.run_start),
		.run_length  (out.run_length)
	);

endmodule
